### rtl/sweep_object_segmenter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sweep object segmenter.
// Each macro is used inside a module that has clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef SWEEP_OBJECT_SEGMENTER_CORE_ASSERT_SVH
`define SWEEP_OBJECT_SEGMENTER_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define SOS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// The consequent holds in the cycle after the antecedent.
`define SOS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/sos_pkg.sv
// ----------------------------------------------------------------------------
// sos_pkg
// Types, constants and the tangent table shared by the segmenter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sos_pkg;

    // Tracker phase codes as they appear on the track_state output.
    typedef enum logic [2:0] {
        PH_BEGIN  = 3'd0,
        PH_FIRST  = 3'd1,
        PH_SECOND = 3'd2,
        PH_OBJECT = 3'd3,
        PH_REJECT = 3'd4,
        PH_STILL  = 3'd5,
        PH_ENDED  = 3'd6
    } phase_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_NEAR_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_MIN_WIDTH      = 2'd1;
    localparam logic [1:0] REG_ANGLE_STEP     = 2'd2;

    localparam logic [15:0] NEAR_THRESHOLD_RST = 16'd1600;
    localparam logic [15:0] MIN_WIDTH_RST      = 16'd64;
    localparam logic [4:0]  ANGLE_STEP_RST     = 5'd2;

    localparam logic [22:0] SUM_MAX   = 23'h7FFFFF;
    localparam logic [5:0]  COUNT_MAX = 6'd63;
    localparam int          SUM_W     = 23;
    localparam int          TAN_DEPTH = 180;
    localparam logic [7:0]  SIZE_WIDE = 8'd180;

    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
    localparam int          TAYLOR_TERMS = 14;

    typedef struct packed {
        logic        start_sweep;
        logic [7:0]  angle;
        logic [15:0] ir_distance;
        logic [15:0] sonar_distance;
    } sample_t;

    typedef struct packed {
        logic [2:0]  track_state;
        logic [5:0]  object_count;
        logic        object_done;
        logic        object_accepted;
        logic [7:0]  object_angle;
        logic [7:0]  angular_size;
        logic [15:0] average_distance;
        logic [15:0] object_width;
    } result_t;

    typedef struct packed {
        logic [15:0] near_threshold;
        logic [15:0] min_width;
        logic [4:0]  angle_step;
    } cfg_t;

    // One classified sample handed from the front to the back.
    typedef struct packed {
        logic        done;
        logic [2:0]  phase;
        logic [5:0]  count;
        logic [7:0]  begin_angle;
        logic [7:0]  end_angle;
        logic [22:0] sum;
        logic [7:0]  run_length;
    } job_t;

    // Outcome of a closed object, returned to the front.
    typedef struct packed {
        logic valid;
        logic reject;
    } fb_t;

    typedef logic [31:0] tan_rom_t [TAN_DEPTH];

    // Unsigned long division by shift and subtract, used to build the table.
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Alternating Taylor series in Q30 with truncated terms.
    function automatic logic [63:0] taylor_q30(input logic [63:0] t0,
                                               input logic [63:0] x,
                                               input logic [63:0] k0);
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] term;
        logic [63:0] k;
        pos  = '0;
        neg  = '0;
        term = t0;
        k    = k0;
        for (int n = 0; n < TAYLOR_TERMS; n++)
        begin
            if (n % 2 == 1)
                neg = neg + term;
            else
                pos = pos + term;
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = udiv64(term, (k + 64'd1) * (k + 64'd2));
            k    = k + 64'd2;
        end
        return (pos > neg) ? pos - neg : 64'd0;
    endfunction

    // Builds tan(s/2 degrees) in unsigned Q16 for every angular size below 180.
    function automatic tan_rom_t build_tan_rom();
        tan_rom_t    rom;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] q;
        for (int i = 0; i < TAN_DEPTH; i++)
        begin
            x = (64'(i) * PI_Q30) / 64'd360;
            s = taylor_q30(x, x, 64'd1);
            c = taylor_q30(ONE_Q30, x, 64'd0);
            if (c == 64'd0)
                q = 64'hFFFFFFFF;
            else
                q = udiv64(s << 16, c);
            rom[i] = q[31:0];
        end
        return rom;
    endfunction

    localparam tan_rom_t TAN_ROM = build_tan_rom();

endpackage

`default_nettype wire

### rtl/sos_fifo.sv
// ----------------------------------------------------------------------------
// sos_fifo
// Small register queue with occupancy count, used between stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sos_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty,
    output logic                  full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_wr;
    logic             do_rd;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and count update; pointers wrap at the depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

### rtl/sos_front.sv
// ----------------------------------------------------------------------------
// sos_front
// Tracker front end: classifies each sample, updates the run state and
// issues one job per sample to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sos_front #(
    parameter int SAMPLES_PER_SWEEP = 128
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sos_pkg::cfg_t    cfg,
    input  wire logic             push,
    input  wire sos_pkg::sample_t sample,
    output logic                  full,
    input  wire logic             job_full,
    output logic                  job_push,
    output sos_pkg::job_t         job,
    input  wire sos_pkg::fb_t     fb
);

    localparam logic [7:0] RUN_CAP =
        (SAMPLES_PER_SWEEP < 255) ? 8'(SAMPLES_PER_SWEEP) : 8'd255;

    logic [2:0]  phase_reg,  phase_next;
    logic [7:0]  begin_reg,  begin_next;
    logic [22:0] sum_reg,    sum_next;
    logic [7:0]  len_reg,    len_next;
    logic [5:0]  count_reg,  count_next;
    logic        pending_reg;

    logic [2:0]  ph;
    logic [7:0]  bg;
    logic [22:0] sm;
    logic [7:0]  ln;
    logic [5:0]  ct;
    logic        is_near;
    logic        is_far;
    logic        acc_ok;
    logic [23:0] sum_wide;
    logic        done;
    logic [7:0]  end_angle;
    logic [15:0] th;
    logic [15:0] sonar;

    // A closed object holds off new samples until its outcome returns.
    assign full     = pending_reg || job_full;
    assign job_push = push && !full;

    assign th    = cfg.near_threshold;
    assign sonar = sample.sonar_distance;

    // Classification and next state of the tracker.
    always_comb
    begin
        ph = sample.start_sweep ? sos_pkg::PH_BEGIN : phase_reg;
        bg = sample.start_sweep ? 8'd0  : begin_reg;
        sm = sample.start_sweep ? 23'd0 : sum_reg;
        ln = sample.start_sweep ? 8'd0  : len_reg;
        ct = sample.start_sweep ? 6'd0  : count_reg;

        is_near  = (sonar < th) && (sample.ir_distance < th);
        is_far   = (sonar > th) || (sample.ir_distance > th);
        sum_wide = {1'b0, sm} + {8'd0, sonar};
        acc_ok   = (ln < RUN_CAP) && (sum_wide <= {1'b0, sos_pkg::SUM_MAX});
        end_angle = (sample.angle >= {3'd0, cfg.angle_step})
                  ? sample.angle - {3'd0, cfg.angle_step} : 8'd0;

        phase_next = ph;
        begin_next = bg;
        sum_next   = sm;
        len_next   = ln;
        count_next = ct;
        done       = 1'b0;

        if (is_near)
        begin
            case (ph)
                sos_pkg::PH_BEGIN, sos_pkg::PH_REJECT, sos_pkg::PH_ENDED:
                begin
                    phase_next = sos_pkg::PH_FIRST;
                    begin_next = sample.angle;
                    sum_next   = {7'd0, sonar};
                    len_next   = 8'd1;
                end
                sos_pkg::PH_FIRST, sos_pkg::PH_SECOND,
                sos_pkg::PH_OBJECT, sos_pkg::PH_STILL:
                begin
                    if (ph == sos_pkg::PH_FIRST)
                        phase_next = sos_pkg::PH_SECOND;
                    else if (ph == sos_pkg::PH_SECOND)
                        phase_next = sos_pkg::PH_OBJECT;
                    else
                        phase_next = sos_pkg::PH_STILL;
                    if (acc_ok)
                    begin
                        sum_next = sum_wide[22:0];
                        len_next = ln + 8'd1;
                    end
                    if (ph == sos_pkg::PH_SECOND && ct < sos_pkg::COUNT_MAX)
                        count_next = ct + 6'd1;
                end
                default:
                begin
                    phase_next = ph;
                end
            endcase
        end
        else if (is_far)
        begin
            case (ph)
                sos_pkg::PH_FIRST, sos_pkg::PH_SECOND:
                begin
                    phase_next = (ct == 6'd0) ? sos_pkg::PH_BEGIN : sos_pkg::PH_REJECT;
                    sum_next   = 23'd0;
                    len_next   = 8'd0;
                end
                sos_pkg::PH_OBJECT, sos_pkg::PH_STILL:
                begin
                    phase_next = sos_pkg::PH_ENDED;
                    sum_next   = 23'd0;
                    len_next   = 8'd0;
                    done       = 1'b1;
                end
                default:
                begin
                    phase_next = ph;
                end
            endcase
        end

        job.done        = done;
        job.phase       = phase_next;
        job.count       = count_next;
        job.begin_angle = bg;
        job.end_angle   = end_angle;
        job.sum         = sm;
        job.run_length  = ln;
    end

    // Tracker state; the count is corrected when a closed object is rejected.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= sos_pkg::PH_BEGIN;
            begin_reg   <= '0;
            sum_reg     <= '0;
            len_reg     <= '0;
            count_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else if (job_push)
        begin
            phase_reg   <= phase_next;
            begin_reg   <= begin_next;
            sum_reg     <= sum_next;
            len_reg     <= len_next;
            count_reg   <= count_next;
            pending_reg <= done;
        end
        else if (fb.valid)
        begin
            pending_reg <= 1'b0;
            if (fb.reject && count_reg != 6'd0)
                count_reg <= count_reg - 6'd1;
        end
    end

endmodule

`default_nettype wire

### rtl/sos_back.sv
// ----------------------------------------------------------------------------
// sos_back
// Back end: for a closed object it divides the distance sum by the run
// length one bit a cycle, multiplies by the tangent and saturates the width.
// ----------------------------------------------------------------------------
`default_nettype none

module sos_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sos_pkg::cfg_t  cfg,
    input  wire logic           job_empty,
    input  wire sos_pkg::job_t  job,
    output logic                job_pop,
    input  wire logic           res_full,
    output logic                res_push,
    output sos_pkg::result_t    res,
    output sos_pkg::fb_t        fb
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_FIN  = 4'b1000
    } back_state_t;

    back_state_t state_reg, state_next;
    sos_pkg::job_t job_reg;
    logic [7:0]  size_reg;
    logic [7:0]  centre_reg;
    logic [8:0]  rem_reg;
    logic [22:0] quo_reg;
    logic [4:0]  bit_reg;
    logic [47:0] prod_reg;

    logic [8:0]  centre_sum;
    logic [7:0]  size_val;
    logic [8:0]  rem_shift;
    logic        rem_ge;
    logic [15:0] avg;
    logic [31:0] tan_val;
    logic [15:0] width;
    logic        accepted;
    logic        take;

    assign take       = (state_reg == ST_IDLE) && !job_empty && !res_full;
    assign job_pop    = take;
    assign centre_sum = {1'b0, job.end_angle} + {1'b0, job.begin_angle};
    assign size_val   = (job.end_angle >= job.begin_angle)
                      ? job.end_angle - job.begin_angle : 8'd0;
    assign rem_shift  = {rem_reg[7:0], quo_reg[22]};
    assign rem_ge     = rem_shift >= {1'b0, job_reg.run_length};
    assign avg        = (job_reg.run_length == 8'd0) ? 16'd0 : quo_reg[15:0];
    assign tan_val    = (size_reg < sos_pkg::SIZE_WIDE) ? sos_pkg::TAN_ROM[size_reg] : 32'd0;

    // Width saturation and acceptance of the closed object.
    always_comb
    begin
        if (size_reg >= sos_pkg::SIZE_WIDE || prod_reg[47:31] != 17'd0)
            width = 16'hFFFF;
        else
            width = prod_reg[30:15];
        accepted = width > cfg.min_width;
    end

    // Result formation: a plain sample passes straight through.
    always_comb
    begin
        res      = '0;
        res_push = 1'b0;
        fb       = '0;
        if (take && !job.done)
        begin
            res.track_state  = job.phase;
            res.object_count = job.count;
            res_push         = 1'b1;
        end
        else if (state_reg == ST_FIN)
        begin
            res.track_state      = job_reg.phase;
            res.object_count     = (!accepted && job_reg.count != 6'd0)
                                 ? job_reg.count - 6'd1 : job_reg.count;
            res.object_done      = 1'b1;
            res.object_accepted  = accepted;
            res.object_angle     = centre_reg;
            res.angular_size     = size_reg;
            res.average_distance = avg;
            res.object_width     = width;
            res_push             = 1'b1;
            fb.valid             = 1'b1;
            fb.reject            = !accepted;
        end
    end

    // Sequencer state transitions.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (take && job.done) state_next = ST_DIV;
            ST_DIV:  if (bit_reg == 5'd0) state_next = ST_MUL;
            ST_MUL:  state_next = ST_FIN;
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath: restoring division, then the tangent product.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            job_reg    <= job;
            size_reg   <= size_val;
            centre_reg <= centre_sum[8:1];
            rem_reg    <= 9'd0;
            quo_reg    <= job.sum;
            bit_reg    <= 5'(sos_pkg::SUM_W - 1);
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= rem_ge ? rem_shift - {1'b0, job_reg.run_length} : rem_shift;
            quo_reg <= {quo_reg[21:0], rem_ge};
            bit_reg <= bit_reg - 5'd1;
        end
        else if (state_reg == ST_MUL)
        begin
            prod_reg <= {32'd0, avg} * {16'd0, tan_val};
        end
    end

endmodule

`default_nettype wire

### rtl/sweep_object_segmenter_core.sv
// A sample that closes no object passes the job queue and is written into the
// result queue when the back end takes it; a sample that closes an object passes
// the job queue, the 23 steps of the bit-serial divider, a multiply and a result state.
// Throughput: one sample per cycle while no object closes and results drain;
// after a closing sample the input stays full until its width is known.
// Reset clears tracker state, queues and config registers to reset values at once.
// ----------------------------------------------------------------------------
// sweep_object_segmenter_core
// Segments a range-sensor sweep into objects and reports their geometry.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sweep_object_segmenter_core_assert.svh"

module sweep_object_segmenter_core #(
    parameter int SAMPLES_PER_SWEEP = 128
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [1:0]       wr_index,
    input  wire logic [15:0]      wr_data,
    input  wire logic             push,
    input  wire sos_pkg::sample_t sample,
    output logic                  full,
    input  wire logic             pop,
    output sos_pkg::result_t      result,
    output logic                  empty
);

    localparam int JOB_W = $bits(sos_pkg::job_t);
    localparam int RES_W = $bits(sos_pkg::result_t);

    sos_pkg::cfg_t    cfg_reg;
    sos_pkg::job_t    job_in;
    sos_pkg::job_t    job_out;
    sos_pkg::result_t res_in;
    sos_pkg::fb_t     fb;
    logic             job_push;
    logic             job_pop;
    logic             job_full;
    logic             job_empty;
    logic             res_push;
    logic             res_full;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_threshold <= sos_pkg::NEAR_THRESHOLD_RST;
            cfg_reg.min_width      <= sos_pkg::MIN_WIDTH_RST;
            cfg_reg.angle_step     <= sos_pkg::ANGLE_STEP_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                sos_pkg::REG_NEAR_THRESHOLD: cfg_reg.near_threshold <= wr_data;
                sos_pkg::REG_MIN_WIDTH:      cfg_reg.min_width      <= wr_data;
                sos_pkg::REG_ANGLE_STEP:     cfg_reg.angle_step     <= wr_data[4:0];
                default:                     cfg_reg                <= cfg_reg;
            endcase
        end
    end

    sos_front #(
        .SAMPLES_PER_SWEEP(SAMPLES_PER_SWEEP)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .sample   (sample),
        .full     (full),
        .job_full (job_full),
        .job_push (job_push),
        .job      (job_in),
        .fb       (fb)
    );

    sos_fifo #(
        .WIDTH(JOB_W),
        .DEPTH(2)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .empty   (job_empty),
        .full    (job_full)
    );

    sos_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in),
        .fb        (fb)
    );

    sos_fifo #(
        .WIDTH(RES_W),
        .DEPTH(2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty),
        .full    (res_full)
    );

    // An object outcome only returns while the front is holding off input.
    `SOS_ASSERT_IMPLY(a_fb_while_held, fb.valid, full)
    // The back never writes a full result queue.
    `SOS_ASSERT_IMPLY(a_res_no_overflow, res_push, !res_full)
    // After an outcome returns, the front is released unless the job queue is full.
    `SOS_ASSERT_NEXT(a_release_after_fb, fb.valid && !job_full, !full || job_full)

endmodule

`default_nettype wire

### verif/sweep_object_segmenter_checker.sv
// ----------------------------------------------------------------------------
// Sweep object segmenter checker
// Watches the sample and result queues of the segmenter. It keeps its own
// copy of the tracker state and registers, predicts one result per accepted
// sample and compares every popped result with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module sweep_object_segmenter_checker
    import sos_pkg::*;
#(
    parameter int SAMPLES_PER_SWEEP = 128
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire logic [1:0]  wr_index,
    input  wire logic [15:0] wr_data,
    input  wire logic    push,
    input  wire sample_t sample,
    input  wire logic    full,
    input  wire logic    pop,
    input  wire result_t result,
    input  wire logic    empty,
    output int           fail_count,
    output int           pending
);

    localparam int RUN_CAP = (SAMPLES_PER_SWEEP < 255) ? SAMPLES_PER_SWEEP : 255;

    // Shadow registers and tracker state.
    logic [15:0] thr_q;
    logic [15:0] minw_q;
    logic [4:0]  step_q;
    phase_t      ph_q;
    logic [7:0]  beg_q;
    logic [22:0] sum_q;
    logic [7:0]  len_q;
    logic [5:0]  cnt_q;

    result_t expected_results[$];
    logic [31:0] tangent_q16[180];

    assign pending = expected_results.size();

    // Alternating series in Q30, terms truncated at each step.
    function automatic logic [63:0] series_q30(logic [63:0] t0, logic [63:0] x,
                                               logic [63:0] k0);
        logic [63:0] p;
        logic [63:0] m;
        logic [63:0] t;
        logic [63:0] k;
        p = 0;
        m = 0;
        t = t0;
        k = k0;
        for (int n = 0; n < 14; n++)
        begin
            if (n[0])
                m += t;
            else
                p += t;
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            t = t / ((k + 1) * (k + 2));
            k += 2;
        end
        return (p > m) ? p - m : 64'd0;
    endfunction

    initial
    begin
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] q;
        for (int i = 0; i < 180; i++)
        begin
            x = (64'(i) * 64'd3373259426) / 64'd360;
            s = series_q30(x, x, 64'd1);
            c = series_q30(64'd1 << 30, x, 64'd0);
            q = (c == 0) ? 64'hFFFFFFFF : (s << 16) / c;
            tangent_q16[i] = q[31:0];
        end
    end

    task automatic add_sonar(logic [15:0] d);
        if (int'(len_q) < RUN_CAP && 32'(sum_q) + 32'(d) <= 32'h7FFFFF)
        begin
            sum_q = sum_q + 23'(d);
            len_q = len_q + 8'd1;
        end
    endtask

    // Advances the shadow tracker by one sample and queues its result.
    task automatic track_sample(sample_t smp);
        result_t r;
        logic near_s;
        logic far_s;
        logic [7:0] end_a;
        logic [63:0] w;
        r = '0;
        if (smp.start_sweep)
        begin
            ph_q = PH_BEGIN;
            beg_q = 0;
            sum_q = 0;
            len_q = 0;
            cnt_q = 0;
        end
        near_s = smp.sonar_distance < thr_q && smp.ir_distance < thr_q;
        far_s = smp.sonar_distance > thr_q || smp.ir_distance > thr_q;
        if (near_s)
        begin
            case (ph_q)
                PH_BEGIN, PH_REJECT, PH_ENDED:
                begin
                    ph_q = PH_FIRST;
                    beg_q = smp.angle;
                    sum_q = 23'(smp.sonar_distance);
                    len_q = 1;
                end
                PH_FIRST:
                begin
                    ph_q = PH_SECOND;
                    add_sonar(smp.sonar_distance);
                end
                PH_SECOND:
                begin
                    ph_q = PH_OBJECT;
                    add_sonar(smp.sonar_distance);
                    if (cnt_q < 63)
                        cnt_q++;
                end
                PH_OBJECT, PH_STILL:
                begin
                    ph_q = PH_STILL;
                    add_sonar(smp.sonar_distance);
                end
                default:;
            endcase
        end
        else if (far_s)
        begin
            if (ph_q == PH_FIRST || ph_q == PH_SECOND)
            begin
                ph_q = (cnt_q == 0) ? PH_BEGIN : PH_REJECT;
                sum_q = 0;
                len_q = 0;
            end
            else if (ph_q == PH_OBJECT || ph_q == PH_STILL)
            begin
                end_a = (smp.angle >= 8'(step_q)) ? smp.angle - 8'(step_q) : 8'd0;
                ph_q = PH_ENDED;
                r.object_done = 1;
                r.object_angle = 8'((9'(end_a) + 9'(beg_q)) >> 1);
                r.angular_size = (end_a >= beg_q) ? end_a - beg_q : 8'd0;
                r.average_distance = (len_q != 0) ? 16'(sum_q / 23'(len_q)) : 16'd0;
                if (r.angular_size >= 180)
                    w = 64'hFFFF;
                else
                    w = (64'd2 * 64'(r.average_distance)
                         * 64'(tangent_q16[r.angular_size])) >> 16;
                r.object_width = (w > 64'hFFFF) ? 16'hFFFF : w[15:0];
                sum_q = 0;
                len_q = 0;
                if (r.object_width > minw_q)
                    r.object_accepted = 1;
                else if (cnt_q > 0)
                    cnt_q--;
            end
        end
        r.track_state = ph_q;
        r.object_count = cnt_q;
        expected_results.push_back(r);
    endtask

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Register writes, sample requests and result requests.
    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            thr_q = NEAR_THRESHOLD_RST;
            minw_q = MIN_WIDTH_RST;
            step_q = ANGLE_STEP_RST;
            ph_q = PH_BEGIN;
            beg_q = 0;
            sum_q = 0;
            len_q = 0;
            cnt_q = 0;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_NEAR_THRESHOLD: thr_q = wr_data;
                    REG_MIN_WIDTH: minw_q = wr_data;
                    REG_ANGLE_STEP: step_q = wr_data[4:0];
                    default:;
                endcase
            end
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result popped with no sample waiting for it");
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("track_state", e.track_state, result.track_state);
                    check_field("object_count", e.object_count, result.object_count);
                    check_field("object_done", e.object_done, result.object_done);
                    check_field("object_accepted", e.object_accepted,
                                result.object_accepted);
                    check_field("object_angle", e.object_angle, result.object_angle);
                    check_field("angular_size", e.angular_size, result.angular_size);
                    check_field("average_distance", e.average_distance,
                                result.average_distance);
                    check_field("object_width", e.object_width, result.object_width);
                end
            end
            if (push && !full)
                track_sample(sample);
        end
    end

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// Sweep object segmenter testbench
// Drives directed and random sweeps through the segmenter under several
// idling phases, reprograms its registers between phases, and reports the
// checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import sos_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    logic [1:0]  wr_index;
    logic [15:0] wr_data;
    logic        push;
    sample_t     sample;
    logic        full;
    logic        pop;
    result_t     result;
    logic        empty;
    int          fail_count;
    int          pending;

    int send_idle_pct;
    int recv_stall_pct;
    logic [15:0] thr_now;
    logic [7:0]  angle_now;

    sweep_object_segmenter_core dut (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data), .push(push), .sample(sample), .full(full),
        .pop(pop), .result(result), .empty(empty)
    );

    sweep_object_segmenter_checker checker_i (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data), .push(push), .sample(sample), .full(full),
        .pop(pop), .result(result), .empty(empty),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Result side stalls at random according to the current phase.
    always @(negedge clk)
        pop <= ($urandom_range(99) >= recv_stall_pct);

    // Hard limit on the run.
    initial
    begin
        #40000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Offers one sample request and holds it until it is taken.
    task automatic send(logic st, logic [7:0] ang, logic [15:0] ir, logic [15:0] so);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        sample <= '{start_sweep: st, angle: ang, ir_distance: ir, sonar_distance: so};
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        if (idx == REG_NEAR_THRESHOLD)
            thr_now = val;
        @(negedge clk);
    endtask

    // Waits until all results are out and the block has gone quiet.
    task automatic drain();
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // A distance around the threshold: mostly near or far, sometimes equal or random.
    function automatic logic [15:0] pick_dist(bit want_near);
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return thr_now;
        if (r < 10)
            return 16'($urandom);
        if (want_near)
            return (thr_now == 0) ? 16'd0 : 16'($urandom_range(thr_now - 1));
        return (thr_now == 16'hFFFF) ? 16'hFFFF
               : 16'($urandom_range(65535, thr_now + 1));
    endfunction

    task automatic random_sweep(int n);
        bit nr;
        angle_now = 8'($urandom_range(180));
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                nr = !nr;
            send((i == 0) ? 1'b1 : ($urandom_range(99) == 0), angle_now,
                 pick_dist(nr), pick_dist(nr));
            angle_now = ($urandom_range(9) == 0) ? 8'($urandom)
                        : 8'(($urandom_range(3) + angle_now) % 181);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        push = 1'b0;
        sample = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        thr_now = NEAR_THRESHOLD_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: threshold equality, short runs, an object, a wide object.
        send(1, 0, 16'hFFFF, 16'hFFFF);
        send(0, 2, 1600, 100);
        send(0, 4, 100, 100);
        send(0, 6, 2000, 100);
        send(0, 8, 0, 0);
        send(0, 10, 100, 100);
        send(0, 12, 100, 1600);
        send(0, 14, 200, 200);
        send(0, 16, 300, 300);
        send(0, 18, 3000, 3000);
        send(0, 20, 16'hFFFF, 0);
        send(0, 0, 5, 5);
        send(0, 1, 5, 5);
        send(0, 1, 5, 5);
        send(0, 1, 9000, 9000);
        send(1, 0, 1500, 1599);
        send(0, 90, 1500, 1599);
        send(0, 180, 1500, 1599);
        send(0, 182, 1599, 1500);
        send(0, 255, 16'hFFFF, 16'hFFFF);
        drain();

        // Extremes of the registers with a long run.
        write_reg(REG_NEAR_THRESHOLD, 16'hFFFF);
        write_reg(REG_MIN_WIDTH, 16'hFFFF);
        write_reg(REG_ANGLE_STEP, 16'd16);
        send(1, 0, 16'hFFFE, 16'hFFFE);
        for (int i = 0; i < 140; i++)
            send(0, 8'(i), 16'hFFFE, 16'hFFFE);
        send(0, 8, 16'hFFFF, 0);
        send(0, 9, 0, 0);
        drain();
        write_reg(REG_NEAR_THRESHOLD, 16'd0);
        write_reg(REG_MIN_WIDTH, 16'd0);
        write_reg(REG_ANGLE_STEP, 16'd1);
        send(0, 3, 0, 0);
        send(0, 4, 1, 0);
        drain();

        // Random phases with different idling and register settings.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 60 : 25) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 60 : 25) : 0;
            write_reg(REG_NEAR_THRESHOLD, 16'($urandom_range(100, 60000)));
            write_reg(REG_MIN_WIDTH, (ph == 0) ? 16'd0 : 16'($urandom_range(4000)));
            write_reg(REG_ANGLE_STEP, 16'($urandom_range(1, 16)));
            repeat (5)
                random_sweep(50);
            drain();
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+rtl
rtl/sos_pkg.sv
rtl/sos_fifo.sv
rtl/sos_front.sv
rtl/sos_back.sv
rtl/sweep_object_segmenter_core.sv
verif/sweep_object_segmenter_checker.sv
verif/tb.sv
